[design/detection_head_decode_macros.svh]
// Assertion helpers for the detection head decoder.
`ifndef DETECTION_HEAD_DECODE_MACROS_SVH
`define DETECTION_HEAD_DECODE_MACROS_SVH

`ifndef SYNTHESIS

// ante holds -> cons holds in the same cycle
`define HDD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hdd: same-cycle check failed");

// ante holds -> cons holds in the next cycle
`define HDD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hdd: next-cycle check failed");

// cond must never hold
`define HDD_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("hdd: forbidden condition seen");

`else

`define HDD_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define HDD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define HDD_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

[design/hdd_pkg.sv]
package hdd_pkg;

  localparam int VAL_W          = 32;
  localparam int CLASS_W        = 7;
  localparam int SCORE_W        = 17;
  localparam int COORD_W        = 13;
  localparam int ANCHOR_W       = 14;
  localparam int POS_W          = 8;

  localparam int MAX_CLASSES    = 128;
  localparam int MAX_ANCHORS    = 16384;

  localparam int BOX_CHANNELS   = 4;
  localparam int BOX_IDX_W      = 2;
  localparam int SCORE_POS      = 4;   // format 1: score channel
  localparam int CORNER_LAST_POS = 5;  // format 1: class channel, last of six

  localparam logic [SCORE_W-1:0] SCORE_ONE = 17'h10000;

  // Corner math: d at 2^17 scale, product at 2^33 scale
  localparam int PAD_SH   = 17;
  localparam int FRAC_SH  = 33;
  localparam int D_W      = 34;
  localparam int INV_W    = 25;
  localparam int P_W      = D_W + INV_W + 1;
  localparam int LIM_W    = COORD_W + 1;
  localparam int CLAMP_W  = FRAC_SH + COORD_W;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_ADDR_W  = 5;
  localparam int CFG_DATA_W  = 32;

  localparam logic FMT_CENTER = 1'b0;
  localparam logic FMT_CORNER = 1'b1;

  typedef enum logic [2:0] {
    REG_OUTPUT_FORMAT   = 3'd0,
    REG_CLASS_COUNT     = 3'd1,
    REG_SCORE_THRESHOLD = 3'd2,
    REG_INVERSE_SCALE   = 3'd3,
    REG_PAD_LEFT        = 3'd4,
    REG_PAD_TOP         = 3'd5,
    REG_IMAGE_WIDTH     = 3'd6,
    REG_IMAGE_HEIGHT    = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic                 output_format;
    logic [7:0]           class_count;
    logic [SCORE_W-1:0]   score_threshold;
    logic [INV_W-1:0]     inverse_scale;
    logic [11:0]          pad_left;
    logic [11:0]          pad_top;
    logic [COORD_W-1:0]   image_width;
    logic [COORD_W-1:0]   image_height;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    output_format:   FMT_CENTER,
    class_count:     8'd80,
    score_threshold: 17'd16384,
    inverse_scale:   25'd65536,
    pad_left:        12'd0,
    pad_top:         12'd0,
    image_width:     13'd640,
    image_height:    13'd480
  };

  typedef struct packed {
    logic [CLASS_W-1:0]   class_id;
    logic [SCORE_W-1:0]   score;
    logic [ANCHOR_W-1:0]  anchor;
  } meta_t;

  // One finished row that passed the threshold
  typedef struct packed {
    logic                    fmt;
    meta_t                   meta;
    logic signed [VAL_W-1:0] b0;
    logic signed [VAL_W-1:0] b1;
    logic signed [VAL_W-1:0] b2;
    logic signed [VAL_W-1:0] b3;
  } row_t;

endpackage

[design/hdd_regs.sv]
module hdd_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [hdd_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [hdd_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [hdd_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready,
  output hdd_pkg::cfg_t                    cfg
);
  import hdd_pkg::*;

  cfg_t     cfg_r;
  cfg_reg_t reg_sel;
  logic     wr_en;

  assign reg_sel = cfg_reg_t'(paddr[CFG_ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        REG_OUTPUT_FORMAT:   cfg_r.output_format   <= pwdata[0];
        REG_CLASS_COUNT:     cfg_r.class_count     <= pwdata[7:0];
        REG_SCORE_THRESHOLD: cfg_r.score_threshold <= pwdata[SCORE_W-1:0];
        REG_INVERSE_SCALE:   cfg_r.inverse_scale   <= pwdata[INV_W-1:0];
        REG_PAD_LEFT:        cfg_r.pad_left        <= pwdata[11:0];
        REG_PAD_TOP:         cfg_r.pad_top         <= pwdata[11:0];
        REG_IMAGE_WIDTH:     cfg_r.image_width     <= pwdata[COORD_W-1:0];
        REG_IMAGE_HEIGHT:    cfg_r.image_height    <= pwdata[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_OUTPUT_FORMAT:   prdata = CFG_DATA_W'(cfg_r.output_format);
      REG_CLASS_COUNT:     prdata = CFG_DATA_W'(cfg_r.class_count);
      REG_SCORE_THRESHOLD: prdata = CFG_DATA_W'(cfg_r.score_threshold);
      REG_INVERSE_SCALE:   prdata = CFG_DATA_W'(cfg_r.inverse_scale);
      REG_PAD_LEFT:        prdata = CFG_DATA_W'(cfg_r.pad_left);
      REG_PAD_TOP:         prdata = CFG_DATA_W'(cfg_r.pad_top);
      REG_IMAGE_WIDTH:     prdata = CFG_DATA_W'(cfg_r.image_width);
      REG_IMAGE_HEIGHT:    prdata = CFG_DATA_W'(cfg_r.image_height);
      default:             prdata = '0;
    endcase
  end

endmodule

[design/hdd_front.sv]
`include "detection_head_decode_macros.svh"

module hdd_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [hdd_pkg::VAL_W-1:0]  in_channel_value,
  input  logic                              in_frame_last,
  input  hdd_pkg::cfg_t                     cfg,
  input  logic                              q_full,
  output logic                              q_push,
  output hdd_pkg::row_t                     q_row
);
  import hdd_pkg::*;

  logic [POS_W-1:0]        channel_position_r;
  logic [ANCHOR_W-1:0]     anchor_counter_r;
  logic signed [VAL_W-1:0] best_score_r, best_score_nxt;
  logic [CLASS_W-1:0]      best_class_r, best_class_nxt;
  logic signed [VAL_W-1:0] box_r   [BOX_CHANNELS];
  logic signed [VAL_W-1:0] box_nxt [BOX_CHANNELS];

  logic                    accept;
  logic [POS_W-1:0]        classes;
  logic [POS_W-1:0]        final_pos;
  logic                    row_end;
  logic                    pass;
  logic [15:0]             rounded;
  logic [CLASS_W-1:0]      round_class;
  logic [SCORE_W-1:0]      score_sat;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (cfg.class_count == '0) begin
      classes = POS_W'(1);
    end else if (cfg.class_count > POS_W'(MAX_CLASSES)) begin
      classes = POS_W'(MAX_CLASSES);
    end else begin
      classes = cfg.class_count;
    end
    final_pos = (cfg.output_format == FMT_CORNER) ? POS_W'(CORNER_LAST_POS)
                                                  : POS_W'(BOX_CHANNELS - 1) + classes;
  end

  // Class channel rounded half away from zero; negative values land on 0
  always_comb begin
    rounded = 16'(in_channel_value[VAL_W-2:16]) + 16'(in_channel_value[15]);
    if (in_channel_value[VAL_W-1]) begin
      round_class = '0;
    end else if (rounded > 16'(MAX_CLASSES - 1)) begin
      round_class = CLASS_W'(MAX_CLASSES - 1);
    end else begin
      round_class = rounded[CLASS_W-1:0];
    end
  end

  always_comb begin
    box_nxt        = box_r;
    best_score_nxt = best_score_r;
    best_class_nxt = best_class_r;
    if (channel_position_r < POS_W'(BOX_CHANNELS)) begin
      box_nxt[channel_position_r[BOX_IDX_W-1:0]] = in_channel_value;
    end else if (cfg.output_format == FMT_CENTER) begin
      if (in_channel_value > best_score_r) begin
        best_score_nxt = in_channel_value;
        best_class_nxt = CLASS_W'(channel_position_r - POS_W'(BOX_CHANNELS));
      end
    end else if (channel_position_r == POS_W'(SCORE_POS)) begin
      best_score_nxt = in_channel_value;
    end else begin
      best_class_nxt = round_class;
    end
  end

  always_comb begin
    row_end = channel_position_r >= final_pos;
    pass    = $signed({best_score_nxt[VAL_W-1], best_score_nxt})
              >= $signed({{(VAL_W + 1 - SCORE_W){1'b0}}, cfg.score_threshold});
    if ($signed(best_score_nxt) > $signed({{(VAL_W - SCORE_W){1'b0}}, SCORE_ONE})) begin
      score_sat = SCORE_ONE;
    end else begin
      score_sat = best_score_nxt[SCORE_W-1:0];
    end
  end

  assign q_push = accept && row_end && pass;

  always_comb begin
    q_row.fmt           = cfg.output_format;
    q_row.meta.class_id = best_class_nxt;
    q_row.meta.score    = score_sat;
    q_row.meta.anchor   = anchor_counter_r;
    q_row.b0            = box_nxt[0];
    q_row.b1            = box_nxt[1];
    q_row.b2            = box_nxt[2];
    q_row.b3            = box_nxt[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channel_position_r <= '0;
      anchor_counter_r   <= '0;
      best_score_r       <= '0;
      best_class_r       <= '0;
      for (int i = 0; i < BOX_CHANNELS; i++) begin
        box_r[i] <= '0;
      end
    end else if (accept) begin
      box_r <= box_nxt;
      if (in_frame_last || row_end) begin
        channel_position_r <= '0;
        best_score_r       <= '0;
        best_class_r       <= '0;
        if (in_frame_last || anchor_counter_r == ANCHOR_W'(MAX_ANCHORS - 1)) begin
          anchor_counter_r <= '0;
        end else begin
          anchor_counter_r <= anchor_counter_r + 1'b1;
        end
      end else begin
        channel_position_r <= channel_position_r + 1'b1;
        best_score_r       <= best_score_nxt;
        best_class_r       <= best_class_nxt;
      end
    end
  end

  `HDD_ASSERT_NEXT(a_push_restarts_row, clk, rst_n, q_push, channel_position_r == '0)

endmodule

[design/hdd_queue.sv]
`include "detection_head_decode_macros.svh"

module hdd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  hdd_pkg::row_t  push_row,
  input  logic           pop,
  output hdd_pkg::row_t  pop_row,
  output logic           empty,
  output logic           full
);
  import hdd_pkg::*;

  row_t              entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign empty   = count_r == '0;
  assign full    = count_r == QCNT_W'(QUEUE_DEPTH);
  assign pop_row = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  `HDD_ASSERT_NEVER(a_no_overflow, clk, rst_n, push && full)
  `HDD_ASSERT_NEVER(a_no_underflow, clk, rst_n, pop && empty)

endmodule

[design/hdd_back.sv]
`include "detection_head_decode_macros.svh"

module hdd_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  hdd_pkg::cfg_t                       cfg,
  input  logic                                q_empty,
  input  hdd_pkg::row_t                       q_row,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [hdd_pkg::CLASS_W-1:0]         out_class_id,
  output logic [hdd_pkg::SCORE_W-1:0]         out_score,
  output logic [hdd_pkg::COORD_W-1:0]         out_box_x,
  output logic [hdd_pkg::COORD_W-1:0]         out_box_y,
  output logic [hdd_pkg::COORD_W-1:0]         out_box_width,
  output logic [hdd_pkg::COORD_W-1:0]         out_box_height,
  output logic [hdd_pkg::ANCHOR_W-1:0]        out_anchor_index
);
  import hdd_pkg::*;

  logic adv;

  // stage 1: corner offsets at 2^17 scale and clamp limits
  logic                    s1_valid_r;
  meta_t                   s1_meta_r;
  logic signed [D_W-1:0]   s1_d_r   [BOX_CHANNELS];
  logic signed [D_W-1:0]   s1_d_nxt [BOX_CHANNELS];
  logic signed [LIM_W-1:0] s1_lim_r   [BOX_CHANNELS];
  logic signed [LIM_W-1:0] s1_lim_nxt [BOX_CHANNELS];

  // stage 2: products at 2^33 scale
  logic                    s2_valid_r;
  meta_t                   s2_meta_r;
  logic signed [P_W-1:0]   s2_p_r   [BOX_CHANNELS];
  logic signed [P_W-1:0]   s2_p_nxt [BOX_CHANNELS];
  logic signed [LIM_W-1:0] s2_lim_r [BOX_CHANNELS];

  // stage 3: clamped corners
  logic                    s3_valid_r;
  meta_t                   s3_meta_r;
  logic [CLAMP_W-1:0]      s3_c_r   [BOX_CHANNELS];
  logic [CLAMP_W-1:0]      s3_c_nxt [BOX_CHANNELS];

  logic                    out_valid_r;
  meta_t                   out_meta_r;
  logic [COORD_W-1:0]      out_x_r, out_y_r, out_w_r, out_h_r;
  logic [COORD_W-1:0]      ext_w, ext_h;
  logic [CLAMP_W:0]        diff_w, diff_h;

  logic signed [D_W-1:0]   two_b0, two_b1, two_b2, two_b3;
  logic signed [D_W-1:0]   ext_b2, ext_b3, pl, pt;
  logic signed [LIM_W-1:0] w_lim, h_lim;
  logic signed [P_W-1:0]   hi [BOX_CHANNELS];

  assign adv   = !out_valid_r || !out_stall;
  assign q_pop = adv && !q_empty;

  always_comb begin
    two_b0 = {{(D_W-VAL_W-1){q_row.b0[VAL_W-1]}}, q_row.b0, 1'b0};
    two_b1 = {{(D_W-VAL_W-1){q_row.b1[VAL_W-1]}}, q_row.b1, 1'b0};
    two_b2 = {{(D_W-VAL_W-1){q_row.b2[VAL_W-1]}}, q_row.b2, 1'b0};
    two_b3 = {{(D_W-VAL_W-1){q_row.b3[VAL_W-1]}}, q_row.b3, 1'b0};
    ext_b2 = {{(D_W-VAL_W){q_row.b2[VAL_W-1]}}, q_row.b2};
    ext_b3 = {{(D_W-VAL_W){q_row.b3[VAL_W-1]}}, q_row.b3};
    pl     = {{(D_W-12-PAD_SH){1'b0}}, cfg.pad_left, {PAD_SH{1'b0}}};
    pt     = {{(D_W-12-PAD_SH){1'b0}}, cfg.pad_top,  {PAD_SH{1'b0}}};
    w_lim  = {1'b0, cfg.image_width};
    h_lim  = {1'b0, cfg.image_height};
    if (q_row.fmt == FMT_CENTER) begin
      s1_d_nxt[0]   = two_b0 - ext_b2 - pl;
      s1_d_nxt[1]   = two_b1 - ext_b3 - pt;
      s1_d_nxt[2]   = two_b0 + ext_b2 - pl;
      s1_d_nxt[3]   = two_b1 + ext_b3 - pt;
      // top-left stops one pixel short of the edge
      s1_lim_nxt[0] = w_lim - 1'b1;
      s1_lim_nxt[1] = h_lim - 1'b1;
    end else begin
      s1_d_nxt[0]   = two_b0 - pl;
      s1_d_nxt[1]   = two_b1 - pt;
      s1_d_nxt[2]   = two_b2 - pl;
      s1_d_nxt[3]   = two_b3 - pt;
      s1_lim_nxt[0] = w_lim;
      s1_lim_nxt[1] = h_lim;
    end
    s1_lim_nxt[2] = w_lim;
    s1_lim_nxt[3] = h_lim;
  end

  always_comb begin
    for (int i = 0; i < BOX_CHANNELS; i++) begin
      s2_p_nxt[i] = s1_d_r[i] * $signed({1'b0, cfg.inverse_scale});
    end
  end

  // negative limit (zero image size) also lands on 0
  always_comb begin
    for (int i = 0; i < BOX_CHANNELS; i++) begin
      hi[i] = {{(P_W-LIM_W-FRAC_SH){s2_lim_r[i][LIM_W-1]}}, s2_lim_r[i], {FRAC_SH{1'b0}}};
      if (s2_lim_r[i][LIM_W-1] || s2_p_r[i][P_W-1]) begin
        s3_c_nxt[i] = '0;
      end else if (s2_p_r[i] > hi[i]) begin
        s3_c_nxt[i] = hi[i][CLAMP_W-1:0];
      end else begin
        s3_c_nxt[i] = s2_p_r[i][CLAMP_W-1:0];
      end
    end
  end

  always_comb begin
    diff_w = {1'b0, s3_c_r[2]} - {1'b0, s3_c_r[0]};
    diff_h = {1'b0, s3_c_r[3]} - {1'b0, s3_c_r[1]};
    ext_w  = diff_w[CLAMP_W] ? '0 : diff_w[CLAMP_W-1:FRAC_SH];
    ext_h  = diff_h[CLAMP_W] ? '0 : diff_h[CLAMP_W-1:FRAC_SH];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= q_pop;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_meta_r  <= q_row.meta;
      s1_d_r     <= s1_d_nxt;
      s1_lim_r   <= s1_lim_nxt;
      s2_meta_r  <= s1_meta_r;
      s2_p_r     <= s2_p_nxt;
      s2_lim_r   <= s1_lim_r;
      s3_meta_r  <= s2_meta_r;
      s3_c_r     <= s3_c_nxt;
      out_meta_r <= s3_meta_r;
      out_x_r    <= s3_c_r[0][CLAMP_W-1:FRAC_SH];
      out_y_r    <= s3_c_r[1][CLAMP_W-1:FRAC_SH];
      out_w_r    <= ext_w;
      out_h_r    <= ext_h;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_class_id     = out_meta_r.class_id;
  assign out_score        = out_meta_r.score;
  assign out_anchor_index = out_meta_r.anchor;
  assign out_box_x        = out_x_r;
  assign out_box_y        = out_y_r;
  assign out_box_width    = out_w_r;
  assign out_box_height   = out_h_r;

  `HDD_ASSERT_NEXT(a_stage3_reaches_output, clk, rst_n, adv && s3_valid_r, out_valid_r)

endmodule

[design/detection_head_decode.sv]
// Channel  Ports                                  Beat
// -------  -------------------------------------  -----------------------------------------
// input    in_valid / in_stall                    one tensor value, frame_last marker
// result   out_valid / out_stall                  one detection per row that passes
// config   psel/penable/pwrite/paddr/pwdata/...   one 32-bit register write, 4-byte stride
//
// One input beat per cycle while in_stall is low; the channel counter and running argmax
// close a row in the cycle of its final beat.
// A passing row enters a 4-entry queue; the box pipeline (offset, multiply, clamp,
// extent) then turns it into the detection, each step in its own registered stage.
// in_stall rises only when the queue is full; out_stall freezes the box pipeline only.
// Synchronous active-low reset clears counters, argmax state, queue and valids, and
// loads the register defaults.
module detection_head_decode (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [hdd_pkg::VAL_W-1:0]   in_channel_value,
  input  logic                               in_frame_last,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [hdd_pkg::CLASS_W-1:0]        out_class_id,
  output logic [hdd_pkg::SCORE_W-1:0]        out_score,
  output logic [hdd_pkg::COORD_W-1:0]        out_box_x,
  output logic [hdd_pkg::COORD_W-1:0]        out_box_y,
  output logic [hdd_pkg::COORD_W-1:0]        out_box_width,
  output logic [hdd_pkg::COORD_W-1:0]        out_box_height,
  output logic [hdd_pkg::ANCHOR_W-1:0]       out_anchor_index,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [hdd_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [hdd_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [hdd_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready
);
  import hdd_pkg::*;

  cfg_t cfg;
  row_t push_row, pop_row;
  logic push, pop, q_empty, q_full;

  hdd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hdd_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_channel_value (in_channel_value),
    .in_frame_last    (in_frame_last),
    .cfg              (cfg),
    .q_full           (q_full),
    .q_push           (push),
    .q_row            (push_row)
  );

  hdd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_row (push_row),
    .pop      (pop),
    .pop_row  (pop_row),
    .empty    (q_empty),
    .full     (q_full)
  );

  hdd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .q_empty          (q_empty),
    .q_row            (pop_row),
    .q_pop            (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_class_id     (out_class_id),
    .out_score        (out_score),
    .out_box_x        (out_box_x),
    .out_box_y        (out_box_y),
    .out_box_width    (out_box_width),
    .out_box_height   (out_box_height),
    .out_anchor_index (out_anchor_index)
  );

endmodule

[sim/detection_head_decode_tb.sv]
module detection_head_decode_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hdd_pkg::*;

  localparam int     CYCLE_LIMIT = 1_000_000;
  localparam longint PIX_ONE     = 64'sd1 <<< FRAC_SH;

  typedef struct packed {
    logic [CLASS_W-1:0]  class_id;
    logic [SCORE_W-1:0]  score;
    logic [COORD_W-1:0]  box_x;
    logic [COORD_W-1:0]  box_y;
    logic [COORD_W-1:0]  box_width;
    logic [COORD_W-1:0]  box_height;
    logic [ANCHOR_W-1:0] anchor_index;
  } detection_t;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic signed [VAL_W-1:0]   in_channel_value;
  logic                      in_frame_last;
  logic                      out_valid;
  logic                      out_stall;
  logic [CLASS_W-1:0]        out_class_id;
  logic [SCORE_W-1:0]        out_score;
  logic [COORD_W-1:0]        out_box_x;
  logic [COORD_W-1:0]        out_box_y;
  logic [COORD_W-1:0]        out_box_width;
  logic [COORD_W-1:0]        out_box_height;
  logic [ANCHOR_W-1:0]       out_anchor_index;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [CFG_ADDR_W-1:0]     paddr;
  logic [CFG_DATA_W-1:0]     pwdata;
  logic [CFG_DATA_W-1:0]     prdata;
  logic                      pready;

  // decoder state as the block should hold it
  cfg_t                      regs = CFG_RESET;
  logic [POS_W-1:0]          chan_pos = '0;
  logic [ANCHOR_W-1:0]       anchor_cnt = '0;
  longint                    best_score = 0;
  logic [CLASS_W-1:0]        best_class = '0;
  longint                    box_val[BOX_CHANNELS] = '{default: 0};

  detection_t                pending_dets[$];
  logic signed [VAL_W-1:0]   row_buf[$];
  bit                        gaps_on = 1'b1;
  int                        err_count = 0;
  int                        cycle_count = 0;
  int unsigned               beats_sent = 0;

  detection_head_decode uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_channel_value (in_channel_value),
    .in_frame_last    (in_frame_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_class_id     (out_class_id),
    .out_score        (out_score),
    .out_box_x        (out_box_x),
    .out_box_y        (out_box_y),
    .out_box_width    (out_box_width),
    .out_box_height   (out_box_height),
    .out_anchor_index (out_anchor_index),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #6 clk = ~clk;

  function automatic bit gap_roll();
    return gaps_on && ($urandom_range(99) < 28);
  endfunction

  function automatic int unsigned live_classes();
    if (regs.class_count == 0) return 1;
    if (regs.class_count > MAX_CLASSES) return MAX_CLASSES;
    return regs.class_count;
  endfunction

  // corner at 2^17 scale -> 2^33 scale, upper bound applied first
  function automatic longint clamp_edge(longint d, longint hi);
    longint p;
    p = d * longint'(regs.inverse_scale);
    if (p > hi) p = hi;
    if (p < 0) p = 0;
    return p;
  endfunction

  function automatic logic [COORD_W-1:0] box_extent(longint lo, longint hi);
    if (hi < lo) return '0;
    return COORD_W'((hi - lo) >>> FRAC_SH);
  endfunction

  task automatic decode_beat(input logic signed [VAL_W-1:0] val, input logic mark);
    longint      v, c, pl, pt, wmax, hmax, sc, xa, ya, xb, yb;
    int unsigned last_pos;
    bit          row_done;
    detection_t  d;
    v = val;
    last_pos = (regs.output_format == FMT_CORNER) ? CORNER_LAST_POS : 3 + live_classes();
    if (chan_pos < BOX_CHANNELS) begin
      box_val[chan_pos[1:0]] = v;
    end else if (regs.output_format == FMT_CENTER) begin
      if (v > best_score) begin
        best_score = v;
        best_class = CLASS_W'(chan_pos - 8'd4);
      end
    end else if (chan_pos == SCORE_POS) begin
      best_score = v;
    end else begin
      // class value rounds half away from zero, then saturates
      if (v >= 0) c = (v + 32768) >>> 16;
      else c = -((-v + 32768) >>> 16);
      if (c < 0) c = 0;
      if (c > 127) c = 127;
      best_class = CLASS_W'(c);
    end
    row_done = chan_pos >= last_pos;

    if (row_done && best_score >= longint'(regs.score_threshold)) begin
      pl = longint'(regs.pad_left) <<< PAD_SH;
      pt = longint'(regs.pad_top) <<< PAD_SH;
      wmax = longint'(regs.image_width) * PIX_ONE;
      hmax = longint'(regs.image_height) * PIX_ONE;
      sc = (best_score > 65536) ? 65536 : best_score;
      if (regs.output_format == FMT_CENTER) begin
        xa = clamp_edge(2 * box_val[0] - box_val[2] - pl,
                        (longint'(regs.image_width) - 1) * PIX_ONE);
        ya = clamp_edge(2 * box_val[1] - box_val[3] - pt,
                        (longint'(regs.image_height) - 1) * PIX_ONE);
        xb = clamp_edge(2 * box_val[0] + box_val[2] - pl, wmax);
        yb = clamp_edge(2 * box_val[1] + box_val[3] - pt, hmax);
      end else begin
        xa = clamp_edge(2 * box_val[0] - pl, wmax);
        ya = clamp_edge(2 * box_val[1] - pt, hmax);
        xb = clamp_edge(2 * box_val[2] - pl, wmax);
        yb = clamp_edge(2 * box_val[3] - pt, hmax);
      end
      d.class_id     = best_class;
      d.score        = SCORE_W'(sc);
      d.box_x        = COORD_W'(xa >>> FRAC_SH);
      d.box_y        = COORD_W'(ya >>> FRAC_SH);
      d.box_width    = box_extent(xa, xb);
      d.box_height   = box_extent(ya, yb);
      d.anchor_index = anchor_cnt;
      pending_dets.insert(pending_dets.size(), d);
    end

    if (mark || row_done) begin
      chan_pos = '0;
      best_score = 0;
      best_class = '0;
      anchor_cnt = mark ? '0 : anchor_cnt + 1'b1;
    end else begin
      chan_pos = chan_pos + 1'b1;
    end
  endtask

  task automatic send_beat(input logic signed [VAL_W-1:0] v, input logic mark);
    @(negedge clk);
    while (gap_roll()) begin
      in_valid <= 1'b0;
      in_channel_value <= $urandom;
      in_frame_last <= 1'($urandom_range(1));
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_channel_value <= v;
    in_frame_last <= mark;
    do @(posedge clk); while (in_stall);
    decode_beat(v, mark);
    beats_sent++;
  endtask

  task automatic send_row(input logic mark_end);
    int k;
    for (k = 0; k < row_buf.size(); k++)
      send_beat(row_buf[k], mark_end && (k == row_buf.size() - 1));
    row_buf.delete();
  endtask

  // drop valid, wait out every pending detection plus pipeline latency
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_dets.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    in_valid <= 1'b0;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (r)
      REG_OUTPUT_FORMAT:   regs.output_format   = value[0];
      REG_CLASS_COUNT:     regs.class_count     = value[7:0];
      REG_SCORE_THRESHOLD: regs.score_threshold = value[SCORE_W-1:0];
      REG_INVERSE_SCALE:   regs.inverse_scale   = value[INV_W-1:0];
      REG_PAD_LEFT:        regs.pad_left        = value[11:0];
      REG_PAD_TOP:         regs.pad_top         = value[11:0];
      REG_IMAGE_WIDTH:     regs.image_width     = value[COORD_W-1:0];
      REG_IMAGE_HEIGHT:    regs.image_height    = value[COORD_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_config(input logic [31:0] fmt, input logic [31:0] classes,
                            input logic [31:0] thresh, input logic [31:0] inv,
                            input logic [31:0] pad_l, input logic [31:0] pad_t,
                            input logic [31:0] img_w, input logic [31:0] img_h);
    drain();
    cfg_write(REG_OUTPUT_FORMAT, fmt);
    cfg_write(REG_CLASS_COUNT, classes);
    cfg_write(REG_SCORE_THRESHOLD, thresh);
    cfg_write(REG_INVERSE_SCALE, inv);
    cfg_write(REG_PAD_LEFT, pad_l);
    cfg_write(REG_PAD_TOP, pad_t);
    cfg_write(REG_IMAGE_WIDTH, img_w);
    cfg_write(REG_IMAGE_HEIGHT, img_h);
  endtask

  function automatic logic signed [VAL_W-1:0] rand_channel(int unsigned k);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 6)
      return $urandom;
    if (k < BOX_CHANNELS)
      return (int'($urandom_range(roll < 50 ? 700 : 4200)) - 40) * 65536
             + int'($urandom_range(65535));
    if (regs.output_format == FMT_CORNER && k == CORNER_LAST_POS)
      return (int'($urandom_range(140)) - 8) * 65536
             + ((roll < 30) ? 32768 : int'($urandom_range(65535)));
    if (roll < 20)
      return -int'($urandom_range(65536));
    return int'($urandom_range(80000));
  endfunction

  // mostly whole rows; a few cut short by a frame end
  task automatic random_row();
    int unsigned n, k, roll;
    n = (regs.output_format == FMT_CORNER) ? 6 : 4 + live_classes();
    roll = $urandom_range(99);
    if (roll < 5) n = $urandom_range(n - 1, 1);
    for (k = 0; k < n; k++)
      send_beat(rand_channel(k), (k == n - 1) && (roll < 5 || roll >= 88));
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    detection_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_dets.size() == 0) begin
        $error("unexpected detection, anchor_index %0d", out_anchor_index);
        err_count++;
      end else begin
        want = pending_dets.pop_front();
        check_field("class_id", want.class_id, out_class_id);
        check_field("score", want.score, out_score);
        check_field("box_x", want.box_x, out_box_x);
        check_field("box_y", want.box_y, out_box_y);
        check_field("box_width", want.box_width, out_box_width);
        check_field("box_height", want.box_height, out_box_height);
        check_field("anchor_index", want.anchor_index, out_anchor_index);
      end
    end
  end

  always @(negedge clk) out_stall <= gap_roll();

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL detection_head_decode");
      $finish;
    end
  end

  task automatic test_center_rows();
    set_config(FMT_CENTER, 2, 16384, 65536, 0, 0, 640, 480);
    // tied scores: the first one wins
    row_buf = '{100 * 65536 + 32768, 50 * 65536, 20 * 65536, 10 * 65536, 58982, 58982};
    send_row(1'b0);
    // extreme values, negative width, score above one
    row_buf = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 98304, -1};
    send_row(1'b1);
  endtask

  task automatic test_corner_rows();
    set_config(FMT_CORNER, 80, 32768, 131072, 16, 8, 4096, 4096);
    row_buf = '{10 * 65536 + 16384, 20 * 65536, 100 * 65536 + 49152, 60 * 65536,
                49152, 2 * 65536 + 32768};
    send_row(1'b0);
    // score right at the threshold, negative half class, x2 left of x1
    row_buf = '{5 * 65536, 5 * 65536, 65536, 65536, 32768, -(2 * 65536 + 32768)};
    send_row(1'b0);
    row_buf = '{0, 0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 65537, 200 * 65536};
    send_row(1'b0);
    row_buf = '{65536, 65536, 2 * 65536, 2 * 65536, 32767, 32'sh80000000};
    send_row(1'b1);
  endtask

  task automatic test_zero_limits();
    // class count zero acts as one; zero scale and zero image size
    set_config(FMT_CENTER, 0, 0, 0, 0, 0, 0, 0);
    row_buf = '{3 * 65536, 4 * 65536, 65536, 65536, -5};
    send_row(1'b0);
    drain();
    cfg_write(REG_INVERSE_SCALE, 65536);
    row_buf = '{3 * 65536, 4 * 65536, 2 * 65536, 2 * 65536, 65536};
    send_row(1'b0);
    drain();
    cfg_write(REG_IMAGE_WIDTH, 640);
    row_buf = '{3 * 65536, 4 * 65536, 2 * 65536, 2 * 65536, 65536};
    send_row(1'b1);
  endtask

  task automatic test_frame_marks();
    set_config(FMT_CORNER, 1, 0, 65536, 0, 0, 640, 480);
    repeat (2) begin
      row_buf = '{65536, 65536, 9 * 65536, 9 * 65536, 40000, 65536};
      send_row(1'b0);
    end
    // frame end before the row completes: partial row dropped
    row_buf = '{65536, 65536, 9 * 65536};
    send_row(1'b1);
    row_buf = '{2 * 65536, 65536, 9 * 65536, 7 * 65536, 50000, 3 * 65536};
    send_row(1'b1);
  endtask

  task automatic test_mid_row_config();
    set_config(FMT_CENTER, 8, 0, 65536, 4, 4, 320, 240);
    row_buf = '{40 * 65536, 30 * 65536, 8 * 65536, 6 * 65536, 20000, 30000};
    send_row(1'b0);
    drain();
    // already past the corner format's last channel: row closes on next beat
    cfg_write(REG_OUTPUT_FORMAT, FMT_CORNER);
    row_buf = '{7 * 65536 + 32768};
    send_row(1'b1);
  endtask

  task automatic test_random_rows();
    int unsigned p, start;
    for (p = 0; p < 10; p++) begin
      set_config(p[0],
                 (p == 2) ? 128 : (p == 4) ? 255 : $urandom_range(6, 1),
                 (p == 1) ? 0 : (p == 3) ? 65536 : $urandom_range(65536),
                 (p == 5) ? 16777216 : (p == 6) ? 1 : (p == 7) ? 32'h1FFFFFF :
                 (p == 9) ? 0 : $urandom_range(131072, 16384),
                 (p == 3) ? 4095 : $urandom_range(200),
                 (p == 5) ? 4095 : $urandom_range(200),
                 (p == 2) ? 4096 : (p == 6) ? 1 : (p == 7) ? 8191 : $urandom_range(4096, 1),
                 (p == 2) ? 4096 : (p == 8) ? 1 : $urandom_range(4096, 1));
      // widest rows run with no idling on either side
      gaps_on = (p != 2);
      start = beats_sent;
      while (beats_sent - start < 35) random_row();
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_channel_value = '0;
    in_frame_last = 1'b0;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_center_rows();
    test_corner_rows();
    test_zero_limits();
    test_frame_marks();
    test_mid_row_config();
    test_random_rows();
    drain();

    if (err_count == 0)
      $display("PASS detection_head_decode");
    else
      $display("FAIL detection_head_decode");
    $finish;
  end

endmodule
